// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked and reset-qualified; empty in
// synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/hsvc_pkg.sv -----
// ---------------------------------------------------------------------------
// hsvc_pkg
// Widths, constants and shared types of the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsvc_pkg;

	localparam int unsigned HUE_W   = 15;
	localparam int unsigned SV_W    = 9;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned FR_W    = 12;   // hue mod 3840
	localparam int unsigned QUO_W   = 4;    // hue div 3840, up to 8
	localparam int unsigned PROD_W  = 20;   // s * k, at most 983040
	localparam int unsigned MUL_W   = 28;   // v * (unit - s*k), at most 2^8 * 983040
	localparam int unsigned SCL_W   = MUL_W + 8;  // times 255
	localparam int unsigned Y_W     = 12;   // floor(.. / 2^24), at most 3825
	localparam int unsigned RCP_W   = 13;

	localparam int unsigned SECTOR_UNITS = 3840;  // 60 degrees in 1/64 steps
	localparam int unsigned SECTOR_COUNT = 6;
	localparam int unsigned QUO_MAX      = 8;     // largest hue div 3840 of a 15-bit hue
	localparam int unsigned ONE_Q8       = 256;
	localparam int unsigned UNIT_NUM     = ONE_Q8 * SECTOR_UNITS;
	// floor(y/15) == floor(y*4370 / 2^16) for y <= 3825
	localparam int unsigned RECIP_15     = 4370;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// load enables of the lane stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// ----- rtl/core/hsvc_in_if.sv -----
// ---------------------------------------------------------------------------
// hsvc_in_if
// HSV input channel: valid/ready handshake with one color per item.
// ---------------------------------------------------------------------------
interface hsvc_in_if;

	logic                          valid;
	logic                          ready;
	logic [hsvc_pkg::HUE_W-1:0]    hue;
	logic [hsvc_pkg::SV_W-1:0]     saturation;
	logic [hsvc_pkg::SV_W-1:0]     brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);

endinterface

// ----- rtl/core/hsvc_out_if.sv -----
// ---------------------------------------------------------------------------
// hsvc_out_if
// RGB output channel: valid/ready handshake with one pixel per item.
// ---------------------------------------------------------------------------
interface hsvc_out_if;

	logic                        valid;
	logic                        ready;
	logic [hsvc_pkg::CH_W-1:0]   red;
	logic [hsvc_pkg::CH_W-1:0]   green;
	logic [hsvc_pkg::CH_W-1:0]   blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);

endinterface

// ----- rtl/core/hsvc_chan.sv -----
// ---------------------------------------------------------------------------
// hsvc_chan
// One intensity term: floor(255 * v * (unit - s*k) / (256*256*3840)),
// three register stages plus the final divide-by-15 step.
// ---------------------------------------------------------------------------
module hsvc_chan (
	input  logic                          clk,
	input  hsvc_pkg::pipe_en_t            en,
	input  logic [hsvc_pkg::SV_W-1:0]     sat,
	input  logic [hsvc_pkg::SV_W-1:0]     bright,
	input  logic [hsvc_pkg::FR_W-1:0]     k,
	output logic [hsvc_pkg::CH_W-1:0]     ch
);

	logic [hsvc_pkg::PROD_W-1:0]   prod_s2;
	logic [hsvc_pkg::SV_W-1:0]     v_s2;
	logic [hsvc_pkg::MUL_W-1:0]    m_s3;
	logic [hsvc_pkg::Y_W-1:0]      y_s4;

	logic [hsvc_pkg::SV_W+hsvc_pkg::FR_W-1:0]        prod_full;
	logic [hsvc_pkg::PROD_W-1:0]                     diff;
	logic [hsvc_pkg::SV_W+hsvc_pkg::PROD_W-1:0]      m_full;
	logic [hsvc_pkg::SCL_W-1:0]                      scaled;
	logic [hsvc_pkg::Y_W+hsvc_pkg::RCP_W-1:0]        quo_full;

	// stage 2: s * k
	assign prod_full = {{hsvc_pkg::FR_W{1'b0}}, sat} * {{hsvc_pkg::SV_W{1'b0}}, k};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= prod_full[hsvc_pkg::PROD_W-1:0];
			v_s2    <= bright;
		end
	end

	// stage 3: v * (unit - s*k)
	assign diff   = hsvc_pkg::PROD_W'(hsvc_pkg::UNIT_NUM) - prod_s2;
	assign m_full = {{hsvc_pkg::PROD_W{1'b0}}, v_s2} * {{hsvc_pkg::SV_W{1'b0}}, diff};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			m_s3 <= m_full[hsvc_pkg::MUL_W-1:0];
		end
	end

	// stage 4: 255*m as (m << 8) - m, then drop the 2^24 part of the denominator
	assign scaled = {m_s3, 8'b0} - {8'b0, m_s3};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4 <= scaled[hsvc_pkg::SCL_W-1 -: hsvc_pkg::Y_W];
		end
	end

	// remaining factor 15 by reciprocal multiply
	assign quo_full = {{hsvc_pkg::RCP_W{1'b0}}, y_s4}
		* {{hsvc_pkg::Y_W{1'b0}}, hsvc_pkg::RCP_W'(hsvc_pkg::RECIP_15)};
	assign ch = quo_full[16 +: hsvc_pkg::CH_W];

endmodule

// ----- rtl/core/hsv_to_rgb_converter_top.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV (hue in 1/64 degree, Q1.8 saturation and value) to 8-bit RGB,
// five-stage pipeline, one item per clock while rgb_out is taken.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  hsv_in    in   valid/ready    hue[14:0], saturation[8:0], brightness[8:0]
//  rgb_out   out  valid/ready    red[7:0], green[7:0], blue[7:0]
//
// Five register stages: an accepted item passes through s1 to s5 in turn, and
// rgb_out.valid rises when it is loaded into s5. One item enters per cycle
// while rgb_out is taken. The 9x20 product in stage 3 sets the depth.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and the input keeps taking items until all five
// stages hold one. arst_n clears only the valid bits.
//
// Every channel is floor(255 * v * (unit - s*k) / (256*256*3840)) with
// unit = 256*3840 and k = 0 (value), 3840 (p), fr (q) or 3840-fr (t).
// Zero saturation collapses all four to grey with no special path.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	hsvc_in_if.sink     hsv_in,
	hsvc_out_if.source  rgb_out
);

	// valid bits and stage enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	hsvc_pkg::pipe_en_t lane_en;

	// stage 1 payload
	logic [hsvc_pkg::SV_W-1:0]   sat_s1;
	logic [hsvc_pkg::SV_W-1:0]   bright_s1;
	logic [hsvc_pkg::FR_W-1:0]   fr_s1;
	hsvc_pkg::sector_t           sec_s1, sec_s2, sec_s3, sec_s4;

	// stage 5 (output register)
	logic [hsvc_pkg::CH_W-1:0]   red_s5, green_s5, blue_s5;

	// stage 1 combinational
	logic [hsvc_pkg::SV_W-1:0]   sat_clip, bright_clip;
	logic [hsvc_pkg::QUO_W-1:0]  quo;
	logic [hsvc_pkg::HUE_W-1:0]  base;
	logic [hsvc_pkg::HUE_W-1:0]  rem_full;
	logic [hsvc_pkg::QUO_W-1:0]  sec_num;

	// lane terms
	logic [hsvc_pkg::FR_W-1:0]   k_t;
	logic [hsvc_pkg::CH_W-1:0]   ch_v, ch_p, ch_q, ch_t;
	logic [hsvc_pkg::CH_W-1:0]   red_d, green_d, blue_d;

	// -----------------------------------------------------------------------
	// Flow control: a stage advances when empty or when its successor does
	// -----------------------------------------------------------------------
	assign en_s5 = !vld_s5 || rgb_out.ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign hsv_in.ready = en_s1;

	assign lane_en.s2 = en_s2;
	assign lane_en.s3 = en_s3;
	assign lane_en.s4 = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsv_in.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: clip S and V to 1.0, split hue into sector and fraction
	// -----------------------------------------------------------------------
	assign sat_clip = (hsv_in.saturation > hsvc_pkg::SV_W'(hsvc_pkg::ONE_Q8))
		? hsvc_pkg::SV_W'(hsvc_pkg::ONE_Q8) : hsv_in.saturation;
	assign bright_clip = (hsv_in.brightness > hsvc_pkg::SV_W'(hsvc_pkg::ONE_Q8))
		? hsvc_pkg::SV_W'(hsvc_pkg::ONE_Q8) : hsv_in.brightness;

	// hue div 3840 from eight parallel threshold compares
	always_comb begin
		quo = '0;
		for (int i = 1; i <= int'(hsvc_pkg::QUO_MAX); i++) begin
			if (hsv_in.hue >= hsvc_pkg::HUE_W'(i * hsvc_pkg::SECTOR_UNITS)) begin
				quo = quo + hsvc_pkg::QUO_W'(1);
			end
		end
	end

	assign base     = hsvc_pkg::HUE_W'(quo) * hsvc_pkg::HUE_W'(hsvc_pkg::SECTOR_UNITS);
	assign rem_full = hsv_in.hue - base;
	// hue of 360 degrees and up wraps the sector
	assign sec_num  = (quo >= hsvc_pkg::QUO_W'(hsvc_pkg::SECTOR_COUNT))
		? quo - hsvc_pkg::QUO_W'(hsvc_pkg::SECTOR_COUNT) : quo;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sat_s1    <= sat_clip;
			bright_s1 <= bright_clip;
			fr_s1     <= rem_full[hsvc_pkg::FR_W-1:0];
			sec_s1    <= hsvc_pkg::sector_t'(sec_num[2:0]);
		end
	end

	// sector travels alongside the lanes
	always_ff @(posedge clk) begin
		if (en_s2) sec_s2 <= sec_s1;
		if (en_s3) sec_s3 <= sec_s2;
		if (en_s4) sec_s4 <= sec_s3;
	end

	// -----------------------------------------------------------------------
	// Stages 2-4: four intensity lanes
	// -----------------------------------------------------------------------
	assign k_t = hsvc_pkg::FR_W'(hsvc_pkg::SECTOR_UNITS) - fr_s1;

	hsvc_chan u_chan_v (
		.clk    (clk),
		.en     (lane_en),
		.sat    (sat_s1),
		.bright (bright_s1),
		.k      ('0),
		.ch     (ch_v)
	);

	hsvc_chan u_chan_p (
		.clk    (clk),
		.en     (lane_en),
		.sat    (sat_s1),
		.bright (bright_s1),
		.k      (hsvc_pkg::FR_W'(hsvc_pkg::SECTOR_UNITS)),
		.ch     (ch_p)
	);

	hsvc_chan u_chan_q (
		.clk    (clk),
		.en     (lane_en),
		.sat    (sat_s1),
		.bright (bright_s1),
		.k      (fr_s1),
		.ch     (ch_q)
	);

	hsvc_chan u_chan_t (
		.clk    (clk),
		.en     (lane_en),
		.sat    (sat_s1),
		.bright (bright_s1),
		.k      (k_t),
		.ch     (ch_t)
	);

	// -----------------------------------------------------------------------
	// Stage 5: six-sector channel assignment into the output register
	// -----------------------------------------------------------------------
	always_comb begin
		case (sec_s4)
			hsvc_pkg::SEC_RED_YEL: begin
				red_d = ch_v; green_d = ch_t; blue_d = ch_p;
			end
			hsvc_pkg::SEC_YEL_GRN: begin
				red_d = ch_q; green_d = ch_v; blue_d = ch_p;
			end
			hsvc_pkg::SEC_GRN_CYN: begin
				red_d = ch_p; green_d = ch_v; blue_d = ch_t;
			end
			hsvc_pkg::SEC_CYN_BLU: begin
				red_d = ch_p; green_d = ch_q; blue_d = ch_v;
			end
			hsvc_pkg::SEC_BLU_MAG: begin
				red_d = ch_t; green_d = ch_p; blue_d = ch_v;
			end
			default: begin
				red_d = ch_v; green_d = ch_p; blue_d = ch_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign rgb_out.valid = vld_s5;
	assign rgb_out.red   = red_s5;
	assign rgb_out.green = green_s5;
	assign rgb_out.blue  = blue_s5;

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	`ASSERT_IMPLIES(a_ready_when_out_empty, clk, arst_n, !vld_s5, hsv_in.ready, "input stalled with empty output stage")
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, hsv_in.valid && hsv_in.ready, vld_s1, "accepted item missing from stage 1")
	`ASSERT_NEXT(a_s4_holds_on_stall, clk, arst_n, vld_s4 && !en_s5, vld_s4 && $stable(sec_s4), "stage 4 item lost under stall")

endmodule
